// ----- src/afrp_pkg.sv -----
// ----------------------------------------------------------------------------
// afrp_pkg
// Shared types and constants of the API frame receive parser.
// ----------------------------------------------------------------------------
package afrp_pkg;

  localparam logic [7:0] StartByte   = 8'h7E;
  localparam logic [7:0] SumGood     = 8'hFF;
  localparam logic [7:0] TypeExplRx  = 8'h91;
  localparam logic [7:0] TypeAtResp  = 8'h88;
  localparam logic [7:0] TypeModem   = 8'h8A;
  localparam logic [7:0] TypeRouteRq = 8'hA3;
  localparam logic [7:0] AtDataStart = 8'h05;
  localparam logic [7:0] ExplRxSkip  = 8'd18;

  localparam logic [2:0] StRxOk    = 3'd0;
  localparam logic [2:0] StAtOk    = 3'd1;
  localparam logic [2:0] StModem   = 3'd2;
  localparam logic [2:0] StRouteRq = 3'd3;
  localparam logic [2:0] StUnknown = 3'd4;
  localparam logic [2:0] StTimeout = 3'd5;
  localparam logic [2:0] StBadStrt = 3'd6;
  localparam logic [2:0] StBadSum  = 3'd7;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;

  typedef enum logic {PhHead, PhBody} phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [63:0] ieee_address;
    logic [15:0] network_address;
    logic [7:0]  source_endpoint;
    logic [7:0]  dest_endpoint;
    logic [15:0] cluster_id;
    logic [15:0] profile_id;
    logic [7:0]  payload_length;
  } result_t;

  // Request as accepted from the slave stream and held in the front queue.
  typedef struct packed {
    logic        tick;
    logic [7:0]  rx_byte;
  } req_t;

endpackage

// ----- src/api_frame_receive_parser_top.sv -----
// ----------------------------------------------------------------------------
// api_frame_receive_parser_top
// Serial API frame receiver: parses frames, passes payload, reports status.
// ----------------------------------------------------------------------------
// Slave stream: one request per received byte (tuser = 0) or timer tick
// (tuser = 1), byte in tdata. Master stream: payload bytes (tuser = 0) and
// one end-of-frame status (tuser = 1, tlast = 1) with header fields.
// A request passes a two-entry queue, then the parser, which handles one
// request per cycle while not stalled and registers its result: the request
// is registered in the queue, then the result in the output register.
// The parser stalls while the output register is full and not taken; the
// queue then fills and s_axis_tready drops. Nothing is dropped.
// Reset empties the queue and output, returns to header search and clears
// timeout_ticks (APB register 0 at address 0).
// ----------------------------------------------------------------------------
`default_nettype none
module api_frame_receive_parser_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [0:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output      logic [31:0]  prdata,
  output      logic         pready,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte
  input  wire logic         s_axis_tuser,   // command
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // data_byte, status, ieee_address, network_address, source_endpoint,
  // dest_endpoint, cluster_id, profile_id, payload_length
  output      logic [151:0] m_axis_tdata,
  output      logic         m_axis_tuser,   // kind
  output      logic         m_axis_tlast    // kind
);
  import afrp_pkg::*;

  logic [15:0] tmo_q;
  logic        q_valid, q_ready;
  req_t        in_req, q_req;
  result_t     res;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {16'd0, tmo_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tmo_q <= '0;
    else if (psel && penable && pwrite && paddr == 1'b0) tmo_q <= pwdata[15:0];
  end

  assign in_req.tick    = s_axis_tuser;
  assign in_req.rx_byte = s_axis_tdata;

  afrp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_req_i(in_req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  afrp_back u_back (
    .clk_i, .rst_ni, .timeout_ticks_i(tmo_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.kind;
  assign m_axis_tdata = {5'd0, res.payload_length, res.profile_id, res.cluster_id,
                         res.dest_endpoint, res.source_endpoint, res.network_address,
                         res.ieee_address, res.status, res.data_byte};

endmodule
`default_nettype wire

// ----- src/afrp_front.sv -----
// ----------------------------------------------------------------------------
// afrp_front
// Input stage and request queue; accepts requests and holds them for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module afrp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire afrp_pkg::req_t in_req_i,
  output      logic          q_valid_o,
  input  wire logic          q_ready_i,
  output      afrp_pkg::req_t q_req_o
);
  import afrp_pkg::*;

  req_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             push, pop;

  assign in_ready_o = (cnt_q != QDepth[QPtrW:0]);
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

endmodule
`default_nettype wire

// ----- src/afrp_back.sv -----
// ----------------------------------------------------------------------------
// afrp_back
// Frame parser and output register; one request per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module afrp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [15:0]      timeout_ticks_i,
  input  wire logic             q_valid_i,
  output      logic             q_ready_o,
  input  wire afrp_pkg::req_t   q_req_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      afrp_pkg::result_t out_res_o
);
  import afrp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  idx_q, idx_d, len_q, len_d, sum_q, sum_d, type_q, type_d, cst_q, cst_d;
  logic        sok_q, sok_d;
  logic [63:0] h0_q, h0_d, h1_q, h1_d;
  logic [15:0] idle_q, idle_d, idle_inc;
  logic        ov_q, emit;
  result_t     res_q, res;
  logic        take;
  logic [7:0]  b, k, ftype, extra;

  assign q_ready_o   = !ov_q || out_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;
  assign b           = q_req_i.rx_byte;
  assign k           = idx_q;

  always_comb begin
    phase_d = phase_q; idx_d = idx_q; len_d = len_q; sum_d = sum_q;
    type_d = type_q; cst_d = cst_q; sok_d = sok_q; h0_d = h0_q; h1_d = h1_q;
    idle_d = idle_q; emit = 1'b0; res = '0; extra = 8'd0;
    idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
    ftype = (k == 8'd0) ? b : type_q;
    if (q_req_i.tick == CmdTick) begin
      if (phase_q == PhBody && timeout_ticks_i != 16'd0) begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_ticks_i) begin
          phase_d = PhHead; idx_d = 8'd0; idle_d = 16'd0;
          emit = 1'b1; res.kind = 1'b1; res.status = StTimeout;
        end
      end
    end else if (phase_q == PhHead) begin
      if (idx_q == 8'd0) begin
        sok_d = (b == StartByte); idx_d = 8'd1;
      end else if (idx_q == 8'd1) begin
        idx_d = 8'd2;
      end else begin
        len_d = b; idx_d = 8'd0;
        if (!sok_q) begin
          emit = 1'b1; res.kind = 1'b1; res.status = StBadStrt;
        end else begin
          phase_d = PhBody; sum_d = 8'd0; type_d = 8'd0; cst_d = 8'd0;
          h0_d = '0; h1_d = '0; idle_d = 16'd0;
        end
      end
    end else begin
      idle_d = 16'd0;
      sum_d = sum_q + b;
      type_d = ftype;
      if (k == len_q) begin
        emit = 1'b1; res.kind = 1'b1;
        phase_d = PhHead; idx_d = 8'd0; idle_d = 16'd0;
        if (sum_d != SumGood) res.status = StBadSum;
        else if (ftype == TypeExplRx) begin
          extra = (len_q > ExplRxSkip) ? len_q - ExplRxSkip : 8'd0;
          res.status = StRxOk; res.ieee_address = h0_q;
          res.network_address = h1_q[15:0]; res.source_endpoint = h1_q[23:16];
          res.dest_endpoint = h1_q[31:24]; res.cluster_id = h1_q[47:32];
          res.profile_id = h1_q[63:48]; res.payload_length = extra;
        end else if (ftype == TypeAtResp) begin
          if (cst_q == 8'd0) begin
            extra = (len_q > AtDataStart) ? len_q - AtDataStart : 8'd0;
            res.status = StAtOk; res.payload_length = extra;
          end else res.status = StUnknown;
        end else if (ftype == TypeModem) begin
          res.status = StModem; res.data_byte = cst_q;
        end else if (ftype == TypeRouteRq) res.status = StRouteRq;
        else res.status = StUnknown;
      end else begin
        idx_d = k + 8'd1;
        if (ftype == TypeExplRx) begin
          if (k >= 8'd1 && k <= 8'd8) h0_d[(8'd8 - k) * 8 +: 8] = h0_q[(8'd8 - k) * 8 +: 8] | b;
          else begin
            case (k)
              8'd9:  h1_d[15:8]  = h1_q[15:8] | b;
              8'd10: h1_d[7:0]   = h1_q[7:0] | b;
              8'd11: h1_d[23:16] = h1_q[23:16] | b;
              8'd12: h1_d[31:24] = h1_q[31:24] | b;
              8'd13: h1_d[47:40] = h1_q[47:40] | b;
              8'd14: h1_d[39:32] = h1_q[39:32] | b;
              8'd15: h1_d[63:56] = h1_q[63:56] | b;
              8'd16: h1_d[55:48] = h1_q[55:48] | b;
              default: begin
                if (k >= ExplRxSkip) begin
                  emit = 1'b1; res.data_byte = b;
                end
              end
            endcase
          end
        end else if (ftype == TypeAtResp) begin
          if (k == 8'd4) cst_d = b;
          else if (k >= AtDataStart && cst_q == 8'd0) begin
            emit = 1'b1; res.data_byte = b;
          end
        end else if (ftype == TypeModem) begin
          if (k == 8'd1) cst_d = b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead; idx_q <= '0; len_q <= '0; sum_q <= '0; type_q <= '0;
      cst_q <= '0; sok_q <= 1'b0; h0_q <= '0; h1_q <= '0; idle_q <= '0; ov_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; idx_q <= idx_d; len_q <= len_d; sum_q <= sum_d;
        type_q <= type_d; cst_q <= cst_d; sok_q <= sok_d; h0_q <= h0_d;
        h1_q <= h1_d; idle_q <= idle_d;
      end
      if (q_ready_o) ov_q <= take && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) res_q <= res;
  end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// API frame receive parser testbench
// Drives framed byte streams and timer ticks into the slave stream, predicts
// payload bytes and end-of-frame status per request, and compares every
// result on the master stream with the prediction in full. The timeout register is
// reprogrammed over APB between phases while the parser is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class frame_scoreboard;
  logic [15:0]  timeout_ticks;
  afrp_pkg::phase_e phase;
  logic [7:0]   byte_index;
  logic [7:0]   frame_length;
  logic [7:0]   running_sum;
  logic         start_ok;
  logic [7:0]   frame_type;
  logic [7:0]   command_status;
  logic [63:0]  ieee_addr;
  logic [63:0]  link_fields;
  logic [15:0]  idle_ticks;
  afrp_pkg::result_t expected_q[$];
  int           mismatches;

  function void clear();
    timeout_ticks = '0;
    phase = afrp_pkg::PhHead;
    byte_index = '0;
    frame_length = '0;
    running_sum = '0;
    start_ok = 1'b0;
    frame_type = '0;
    command_status = '0;
    ieee_addr = '0;
    link_fields = '0;
    idle_ticks = '0;
    expected_q.delete();
    mismatches = 0;
  endfunction

  function void close_frame(ref afrp_pkg::result_t r);
    r.kind = 1'b1;
    if (running_sum != afrp_pkg::SumGood) begin
      r.status = afrp_pkg::StBadSum;
    end else if (frame_type == afrp_pkg::TypeExplRx) begin
      r.status = afrp_pkg::StRxOk;
      r.ieee_address = ieee_addr;
      r.network_address = link_fields[15:0];
      r.source_endpoint = link_fields[23:16];
      r.dest_endpoint = link_fields[31:24];
      r.cluster_id = link_fields[47:32];
      r.profile_id = link_fields[63:48];
      r.payload_length = (frame_length > afrp_pkg::ExplRxSkip) ?
                         frame_length - afrp_pkg::ExplRxSkip : 8'd0;
    end else if (frame_type == afrp_pkg::TypeAtResp) begin
      if (command_status == 8'd0) begin
        r.status = afrp_pkg::StAtOk;
        r.payload_length = (frame_length > afrp_pkg::AtDataStart) ?
                           frame_length - afrp_pkg::AtDataStart : 8'd0;
      end else begin
        r.status = afrp_pkg::StUnknown;
      end
    end else if (frame_type == afrp_pkg::TypeModem) begin
      r.status = afrp_pkg::StModem;
      r.data_byte = command_status;
    end else if (frame_type == afrp_pkg::TypeRouteRq) begin
      r.status = afrp_pkg::StRouteRq;
    end else begin
      r.status = afrp_pkg::StUnknown;
    end
    phase = afrp_pkg::PhHead;
    byte_index = '0;
    idle_ticks = '0;
  endfunction

  function void note_request(logic cmd, logic [7:0] b);
    afrp_pkg::result_t r;
    logic [7:0] k;
    r = '0;
    if (cmd == afrp_pkg::CmdTick) begin
      if (phase != afrp_pkg::PhBody || timeout_ticks == 16'd0) return;
      if (idle_ticks != 16'hFFFF) idle_ticks++;
      if (idle_ticks >= timeout_ticks) begin
        phase = afrp_pkg::PhHead;
        byte_index = '0;
        idle_ticks = '0;
        r.kind = 1'b1;
        r.status = afrp_pkg::StTimeout;
        expected_q.push_back(r);
      end
      return;
    end
    if (phase != afrp_pkg::PhBody) begin
      if (byte_index == 8'd0) begin
        start_ok = (b == afrp_pkg::StartByte);
        byte_index = 8'd1;
      end else if (byte_index == 8'd1) begin
        byte_index = 8'd2;
      end else begin
        frame_length = b;
        byte_index = '0;
        if (!start_ok) begin
          r.kind = 1'b1;
          r.status = afrp_pkg::StBadStrt;
          expected_q.push_back(r);
        end else begin
          phase = afrp_pkg::PhBody;
          running_sum = '0;
          frame_type = '0;
          command_status = '0;
          ieee_addr = '0;
          link_fields = '0;
          idle_ticks = '0;
        end
      end
      return;
    end
    idle_ticks = '0;
    k = byte_index;
    running_sum = running_sum + b;
    if (k == 8'd0) frame_type = b;
    if (k == frame_length) begin
      close_frame(r);
      expected_q.push_back(r);
      return;
    end
    byte_index = k + 8'd1;
    if (frame_type == afrp_pkg::TypeExplRx) begin
      if (k >= 1 && k <= 8) ieee_addr[(8 - k) * 8 +: 8] = b;
      else if (k == 9) link_fields[15:8] = b;
      else if (k == 10) link_fields[7:0] = b;
      else if (k == 11) link_fields[23:16] = b;
      else if (k == 12) link_fields[31:24] = b;
      else if (k == 13) link_fields[47:40] = b;
      else if (k == 14) link_fields[39:32] = b;
      else if (k == 15) link_fields[63:56] = b;
      else if (k == 16) link_fields[55:48] = b;
      else if (k >= 18) begin
        r.data_byte = b;
        expected_q.push_back(r);
      end
    end else if (frame_type == afrp_pkg::TypeAtResp) begin
      if (k == 8'd4) command_status = b;
      else if (k >= afrp_pkg::AtDataStart && command_status == 8'd0) begin
        r.data_byte = b;
        expected_q.push_back(r);
      end
    end else if (frame_type == afrp_pkg::TypeModem) begin
      if (k == 8'd1) command_status = b;
    end
  endfunction

  function void check_result(afrp_pkg::result_t got);
    afrp_pkg::result_t exp_r;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected kind %0d data %h status %0d ieee %h net %h",
                 exp_r.kind, exp_r.data_byte, exp_r.status, exp_r.ieee_address,
                 exp_r.network_address);
        $display("  src %h dst %h cl %h pr %h len %0d", exp_r.source_endpoint,
                 exp_r.dest_endpoint, exp_r.cluster_id, exp_r.profile_id,
                 exp_r.payload_length);
        $display("  actual kind %0d data %h status %0d ieee %h net %h",
                 got.kind, got.data_byte, got.status, got.ieee_address,
                 got.network_address);
        $display("  src %h dst %h cl %h pr %h len %0d", got.source_endpoint,
                 got.dest_endpoint, got.cluster_id, got.profile_id,
                 got.payload_length);
      end
    end
  endfunction
endclass

module testbench;
  import afrp_pkg::*;

  localparam int WatchdogLimit = 200000;
  localparam int DrainCycles = 10;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [0:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  frame_scoreboard frames;
  int  idle_cycles;
  int  results_seen;
  int  items_sent;
  bit  rx_stall_enable;
  bit  failed;

  api_frame_receive_parser_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    afrp_pkg::result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        {got.payload_length, got.profile_id, got.cluster_id, got.dest_endpoint,
         got.source_endpoint, got.network_address, got.ieee_address, got.status,
         got.data_byte} = m_axis_tdata[146:0];
        if (m_axis_tlast !== m_axis_tuser || m_axis_tdata[151:147] !== 5'd0) begin
          got.kind = ~m_axis_tuser;
        end
        frames.check_result(got);
        results_seen++;
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("api_frame_receive_parser_top test failed");
        $finish;
      end
      m_axis_tready <= rx_stall_enable ? (pick_gap() == 0) : 1'b1;
    end
  end

  task automatic send_request(logic cmd, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frames.note_request(cmd, b);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(CmdByte, b);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (frames.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    frames.timeout_ticks = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Build frame: header, body of type and filler, optional ticks, then a valid or random checksum.
  task automatic send_frame(logic [7:0] ftype, logic [7:0] len, bit good_sum,
                            int tick_odds);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    send_byte(StartByte);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? ftype : 8'($urandom_range(0, 255));
      if (ftype == TypeAtResp && i == 4 && $urandom_range(0, 2) != 0) b = 8'd0;
      sum = sum + b;
      send_byte(b);
      if (tick_odds > 0 && $urandom_range(0, 99) < tick_odds)
        send_request(CmdTick, 8'($urandom_range(0, 255)));
    end
    send_byte(good_sum ? (SumGood - sum) : 8'($urandom_range(0, 255)));
  endtask

  task automatic random_frame(int tick_odds);
    logic [7:0] ftype;
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0, 1: ftype = TypeExplRx;
      2: ftype = TypeAtResp;
      3: ftype = TypeModem;
      4: ftype = TypeRouteRq;
      default: ftype = 8'($urandom_range(0, 255));
    endcase
    send_frame(ftype, 8'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) :
               $urandom_range(0, 30)), $urandom_range(0, 5) != 0, tick_odds);
  endtask

  initial begin
    int base;
    frames = new();
    frames.clear();
    idle_cycles = 0;
    results_seen = 0;
    items_sent = 0;
    rx_stall_enable = 1'b0;
    failed = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_frame(TypeExplRx, 8'd22, 1'b1, 0);
    send_frame(TypeAtResp, 8'd7, 1'b1, 0);
    send_frame(TypeAtResp, 8'd3, 1'b1, 0);
    send_frame(TypeModem, 8'd2, 1'b1, 0);
    send_frame(TypeRouteRq, 8'd0, 1'b1, 0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_request(CmdTick, 8'hFF);
    send_frame(TypeExplRx, 8'd255, 1'b0, 0);
    write_timeout(16'd1);
    send_frame(TypeExplRx, 8'd5, 1'b1, 0);
    send_byte(StartByte);
    send_byte(8'h00);
    send_byte(8'd9);
    send_byte(TypeModem);
    send_request(CmdTick, 8'h00);

    base = items_sent;
    rx_stall_enable = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_timeout(16'd0);
        1: write_timeout(16'hFFFF);
        2: write_timeout(16'($urandom_range(2, 6)));
        3: write_timeout(16'd3);
        default: write_timeout(16'($urandom_range(1, 65535)));
      endcase
      rx_stall_enable = (ph != 3);
      while (items_sent < base + (ph + 1) * 100) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else begin
          random_frame((ph == 2) ? 15 : 3);
        end
        if ($urandom_range(0, 30) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    failed = frames.mismatches != 0 || frames.expected_q.size() != 0;
    if (!failed) begin
      $display("api_frame_receive_parser_top test passed");
    end else begin
      $display("api_frame_receive_parser_top test failed");
    end
    $finish;
  end
endmodule
